/* hw/rtl/lkv_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// Used by lkv_ctrl, lkv_datapath and lru_key_value_cache_top; no dependencies.
`default_nettype none
package lkv_pkg;

	// Port widths of the request and result fields
	localparam int KEY_W   = 64;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	// Default geometry
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Request opcodes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the accepted request
		logic match;   // compare all entries, read value, pick victim
		logic commit;  // update state and load the result register
	} lkv_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/lkv_ctrl.sv */
// Controller for the LRU key-value cache: request sequencing and result handshake.
// Depends on lkv_pkg for the command struct.
`default_nettype none
module lkv_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lkv_pkg::lkv_cmd_t    cmd
);
	import lkv_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_free    = !out_valid || out_ready;
	assign cmd.load    = in_valid && in_ready;
	assign cmd.match   = (state_q == ST_MATCH);
	assign cmd.commit  = (state_q == ST_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					// hold until the result register can take the new result
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lkv_datapath.sv */
// Datapath for the LRU key-value cache: key lanes, recency ranks, value memory,
// capacity register and result register. Depends on lkv_pkg.
`default_nettype none
module lkv_datapath #(
	parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lkv_pkg::lkv_cmd_t           cmd,
	input  wire logic                        cfg_wr_en,
	input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wr_data,
	input  wire logic                        opcode,
	input  wire logic [lkv_pkg::KEY_W-1:0]   entry_key,
	input  wire logic [lkv_pkg::VALUE_W-1:0] entry_value,
	output logic                             hit,
	output logic [lkv_pkg::VALUE_W-1:0]      read_value,
	output logic                             evicted,
	output logic [lkv_pkg::KEY_W-1:0]        evicted_key
);
	import lkv_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = 8;

	// captured request
	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// cache state
	logic [KEY_BITS-1:0]   keys_q [ENTRIES];
	logic [VALUE_BITS-1:0] vals_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [IDX_W-1:0]      rank_q [ENTRIES];
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      cap_q;

	// match results
	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    lru_vec;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      hit_rank;
	logic [KEY_BITS-1:0]   lru_key;
	logic [IDX_W-1:0]      lru_rank;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      eff_cap;
	logic [CMP_W-1:0]      count_ext;
	logic                  need_evict;

	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [IDX_W-1:0]      hit_rank_q;
	logic [ENTRIES-1:0]    lru_vec_q;
	logic [KEY_BITS-1:0]   lru_key_q;
	logic                  evict_q;
	logic [VALUE_BITS-1:0] rd_val_q;

	// commit results
	logic [ENTRIES-1:0]    valid_after;
	logic [IDX_W-1:0]      free_idx;
	logic                  free_found;
	logic                  do_ins;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= KEY_BITS'(entry_key);
			val_q <= VALUE_BITS'(entry_value);
		end
	end

	// parallel compare over all lanes; ranks of valid entries are a permutation
	assign lru_rank = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		match_vec = '0;
		lru_vec   = '0;
		hit_idx   = '0;
		hit_rank  = '0;
		lru_key   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (keys_q[i] == key_q);
			lru_vec[i]   = valid_q[i] && (rank_q[i] == lru_rank);
			if (match_vec[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (lru_vec[i]) lru_key = lru_key | keys_q[i];
		end
	end

	// capacity zero acts as one; saturate at the number of entries
	assign cap_ext   = CMP_W'(cap_q);
	assign count_ext = CMP_W'(count_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign need_evict = (op_q == OP_INSERT) && !(|match_vec) &&
		(count_ext >= eff_cap) && (count_ext != '0);

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_q      <= |match_vec;
			hit_idx_q  <= hit_idx;
			hit_rank_q <= hit_rank;
			lru_vec_q  <= lru_vec;
			lru_key_q  <= lru_key;
			evict_q    <= need_evict;
		end
	end

	// drop the victim, then take the lowest free slot
	always_comb begin
		valid_after = valid_q & ~(evict_q ? lru_vec_q : '0);
		free_idx    = '0;
		free_found  = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				free_idx   = IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	assign do_ins = (op_q == OP_INSERT) && !hit_q && free_found;
	assign wr_en  = cmd.commit && (op_q == OP_INSERT) && (hit_q || free_found);
	assign wr_idx = hit_q ? hit_idx_q : free_idx;

	// value memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) vals_mem[wr_idx] <= val_q;
		if (cmd.match) rd_val_q <= vals_mem[hit_idx];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.commit && do_ins && (free_idx == IDX_W'(i))) keys_q[i] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.commit) begin
			if (hit_q) begin
				// promote: entries more recent than the hit age by one
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit_idx_q == IDX_W'(i)) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
			end else if (op_q == OP_INSERT) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (do_ins && (free_idx == IDX_W'(i))) begin
						rank_q[i] <= '0;
					end else if (valid_after[i] && do_ins) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				valid_q <= valid_after |
					(do_ins ? (ENTRIES'(1) << free_idx) : '0);
				count_q <= count_q - CNT_W'(evict_q) + CNT_W'(do_ins);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit         <= hit_q;
			read_value  <= (hit_q && (op_q == OP_LOOKUP)) ? VALUE_W'(rd_val_q) : '0;
			evicted     <= evict_q;
			evicted_key <= evict_q ? KEY_W'(lru_key_q) : '0;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lru_key_value_cache_top.sv */
// Each accepted request passes through capture, parallel match and commit, and the
// next request is accepted only once the commit is done; a held result stalls only
// the commit step.
// Reset: asynchronous, active low; valid marks, ranks and the entry count clear
// at once, capacity resets to 16. Keys and values are undefined until written.
// Top level of the LRU key-value cache; uses lkv_pkg, lkv_ctrl, lkv_datapath.
`default_nettype none
module lru_key_value_cache_top #(
	parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        opcode,
	input  wire logic [lkv_pkg::KEY_W-1:0]   entry_key,
	input  wire logic [lkv_pkg::VALUE_W-1:0] entry_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             hit,
	output logic [lkv_pkg::VALUE_W-1:0]      read_value,
	output logic                             evicted,
	output logic [lkv_pkg::KEY_W-1:0]        evicted_key
);
	import lkv_pkg::*;

	lkv_cmd_t cmd;

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lkv_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (opcode),
		.entry_key   (entry_key),
		.entry_value (entry_value),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule
`default_nettype wire
